// File: src/swr_pkg.sv
// Shared constants and controller/datapath interface types for the
// sliding-window receiver. No dependencies.
`timescale 1ns / 1ps

package swr_pkg;

  // Sequence space and derived widths
  localparam int SEQ_SPACE  = 256;
  localparam int SEQ_W      = 8;
  localparam int ACK_W      = 9;
  localparam int FRAME_W    = 32;
  localparam int SIZE_W     = 8;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 8'd8;

  // Bitmap is scanned one word per cycle
  localparam int WORD_W     = 32;
  localparam int BIT_IDX_W  = 5;
  localparam int NUM_WORDS  = SEQ_SPACE / WORD_W;
  localparam int WORD_IDX_W = 3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // capture the incoming request
    logic mark;        // set the received mark of the captured frame
    logic scan_start;  // begin the contiguous-mark scan after the frame
    logic scan_step;   // advance the scan by one word
    logic emit_drop;   // send a result for a discarded frame
    logic emit_accept; // send a result for a recorded frame, no ACK
    logic emit_ack;    // send an ACK result and move the left edge
  } swr_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_window;   // captured frame lies in (left, right]
    logic is_next;     // captured frame is left + 1
    logic gap_found;   // scan found the first unreceived frame
  } swr_status_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CHECK = 3'b010,
    ST_SCAN  = 3'b100
  } swr_state_t;

endpackage

// File: src/swr_ctrl.sv
// Controller state machine for the sliding-window receiver.
// Depends on swr_pkg for the state, command and status types.
`timescale 1ns / 1ps

module swr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  swr_pkg::swr_status_t status,
  output swr_pkg::swr_cmd_t    cmd,
  output logic                 busy
);

  swr_pkg::swr_state_t state_r;
  swr_pkg::swr_state_t state_nxt;

  // Decide the next state and the datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      swr_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = swr_pkg::ST_CHECK;
        end
      end
      swr_pkg::ST_CHECK: begin
        if (!status.in_window) begin
          cmd.emit_drop = 1'b1;
          state_nxt     = swr_pkg::ST_IDLE;
        end else if (status.is_next) begin
          cmd.mark       = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt      = swr_pkg::ST_SCAN;
        end else begin
          cmd.mark        = 1'b1;
          cmd.emit_accept = 1'b1;
          state_nxt       = swr_pkg::ST_IDLE;
        end
      end
      swr_pkg::ST_SCAN: begin
        if (status.gap_found) begin
          cmd.emit_ack = 1'b1;
          state_nxt    = swr_pkg::ST_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      default: begin
        state_nxt = swr_pkg::ST_IDLE;
      end
    endcase
  end

  // Hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != swr_pkg::ST_IDLE);

endmodule

// File: src/swr_dpath.sv
// Datapath of the sliding-window receiver: window registers, received
// bitmap, word-wise gap scan and result registers. Depends on swr_pkg.
`timescale 1ns / 1ps

module swr_dpath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  swr_pkg::swr_cmd_t               cmd,
  output swr_pkg::swr_status_t            status,
  input  logic [swr_pkg::FRAME_W-1:0]     in_frame_seq,
  input  logic                            cfg_wr_en,
  input  logic [swr_pkg::SIZE_W-1:0]      cfg_wr_data,
  output logic                            out_valid,
  output logic                            out_accepted,
  output logic                            out_ack_valid,
  output logic [swr_pkg::ACK_W-1:0]       out_ack_number
);

  logic [swr_pkg::FRAME_W-1:0] seq_r;
  logic [swr_pkg::SEQ_W-1:0]   left_r;
  logic [swr_pkg::SIZE_W-1:0]  size_r;
  logic [swr_pkg::NUM_WORDS-1:0][swr_pkg::WORD_W-1:0] map_r;
  logic [swr_pkg::ACK_W-1:0]   idx_r;

  logic                        out_valid_r;
  logic                        out_accepted_r;
  logic                        out_ack_valid_r;
  logic [swr_pkg::ACK_W-1:0]   out_ack_number_r;

  logic [swr_pkg::SEQ_W:0]     right_sum;
  logic [swr_pkg::SEQ_W-1:0]   right_edge;
  logic [swr_pkg::FRAME_W:0]   next_seq;
  logic [swr_pkg::WORD_W-1:0]  low_mask;
  logic [swr_pkg::WORD_W-1:0]  scan_word;
  logic [swr_pkg::BIT_IDX_W-1:0] zero_pos;
  logic                        word_has_zero;
  logic [swr_pkg::ACK_W-1:0]   gap_pos;
  logic [swr_pkg::ACK_W-1:0]   left_minus;
  logic                        frame_in_window;
  logic                        frame_is_next;
  logic                        scan_gap_found;

  // Right edge: left + size, clipped to the end of the sequence space
  always_comb begin
    right_sum  = {1'b0, left_r} + {1'b0, size_r};
    right_edge = right_sum[swr_pkg::SEQ_W] ? {swr_pkg::SEQ_W{1'b1}}
                                           : right_sum[swr_pkg::SEQ_W-1:0];
  end

  // Window test and next-expected test on the captured frame
  always_comb begin
    next_seq        = {{(swr_pkg::FRAME_W+1-swr_pkg::SEQ_W){1'b0}}, left_r}
                      + {{swr_pkg::FRAME_W{1'b0}}, 1'b1};
    frame_in_window = (seq_r > {{(swr_pkg::FRAME_W-swr_pkg::SEQ_W){1'b0}}, left_r}) &&
                      (seq_r <= {{(swr_pkg::FRAME_W-swr_pkg::SEQ_W){1'b0}}, right_edge});
    frame_is_next   = ({1'b0, seq_r} == next_seq);
  end

  // Find the first clear mark in the current word at or after the scan index
  always_comb begin
    low_mask      = (swr_pkg::WORD_W'(1) << idx_r[swr_pkg::BIT_IDX_W-1:0])
                    - swr_pkg::WORD_W'(1);
    scan_word     = map_r[idx_r[swr_pkg::BIT_IDX_W+swr_pkg::WORD_IDX_W-1:
                                swr_pkg::BIT_IDX_W]] | low_mask;
    word_has_zero = ~&scan_word;
    zero_pos      = '0;
    for (int b = swr_pkg::WORD_W - 1; b >= 0; b--) begin
      if (!scan_word[b]) begin
        zero_pos = swr_pkg::BIT_IDX_W'(b);
      end
    end
    if (idx_r[swr_pkg::ACK_W-1]) begin
      gap_pos = swr_pkg::ACK_W'(swr_pkg::SEQ_SPACE);
    end else begin
      gap_pos = {1'b0,
                 idx_r[swr_pkg::BIT_IDX_W+swr_pkg::WORD_IDX_W-1:swr_pkg::BIT_IDX_W],
                 zero_pos};
    end
    scan_gap_found = idx_r[swr_pkg::ACK_W-1] | word_has_zero;
    left_minus     = gap_pos - swr_pkg::ACK_W'(1);
  end

  // Report status to the controller
  assign status = '{in_window: frame_in_window,
                    is_next:   frame_is_next,
                    gap_found: scan_gap_found};

  // Capture the request, step the scan index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      seq_r <= in_frame_seq;
    end
    if (cmd.scan_start) begin
      idx_r <= {1'b0, seq_r[swr_pkg::SEQ_W-1:0]} + swr_pkg::ACK_W'(1);
    end else if (cmd.scan_step) begin
      idx_r <= {idx_r[swr_pkg::ACK_W-1:swr_pkg::BIT_IDX_W] + 4'd1,
                {swr_pkg::BIT_IDX_W{1'b0}}};
    end
  end

  // Window state, configuration and received bitmap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      size_r <= swr_pkg::SIZE_RESET;
      map_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        size_r <= cfg_wr_data;
      end
      if (cmd.mark) begin
        map_r[seq_r[swr_pkg::SEQ_W-1:swr_pkg::BIT_IDX_W]]
             [seq_r[swr_pkg::BIT_IDX_W-1:0]] <= 1'b1;
      end
      if (cmd.emit_ack) begin
        left_r <= left_minus[swr_pkg::SEQ_W-1:0];
      end
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_drop | cmd.emit_accept | cmd.emit_ack;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.emit_drop) begin
      out_accepted_r   <= 1'b0;
      out_ack_valid_r  <= 1'b0;
      out_ack_number_r <= '0;
    end else if (cmd.emit_accept) begin
      out_accepted_r   <= 1'b1;
      out_ack_valid_r  <= 1'b0;
      out_ack_number_r <= '0;
    end else if (cmd.emit_ack) begin
      out_accepted_r   <= 1'b1;
      out_ack_valid_r  <= 1'b1;
      out_ack_number_r <= gap_pos;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_accepted   = out_accepted_r;
  assign out_ack_valid  = out_ack_valid_r;
  assign out_ack_number = out_ack_number_r;

endmodule

// File: src/sliding_window_receiver_core.sv
// Top level of the sliding-window receiver: controller plus datapath.
// Depends on swr_pkg, swr_ctrl and swr_dpath.
//
// Usage:
//   Input: drive in_frame_seq and raise start; the request is taken at an
//   edge where start is high and busy is low. Results: out_valid pulses for
//   one cycle with out_accepted, out_ack_valid and out_ack_number; the
//   receiver must take it in that cycle, there is no back-pressure.
//   Configuration: cfg_wr_en with cfg_wr_data writes the window size; write
//   only while busy is low and no result is pending.
// Processing:
//   A discarded frame or one recorded without advancing the window gives
//   its result, registered from the check state; busy stays high until
//   the result is issued, so a new frame is taken only after that. A frame
//   that advances the window adds the gap scan, which walks the received
//   bitmap one 32-bit word per cycle until it finds a clear mark or
//   reaches the end of the sequence space.
// Reset:
//   Synchronous rst_n clears the window to 0, clears every received mark
//   at once and sets the window size to 8. No clearing pass is needed.
`timescale 1ns / 1ps

module sliding_window_receiver_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [swr_pkg::FRAME_W-1:0]  in_frame_seq,
  input  logic                         cfg_wr_en,
  input  logic [swr_pkg::SIZE_W-1:0]   cfg_wr_data,
  output logic                         out_valid,
  output logic                         out_accepted,
  output logic                         out_ack_valid,
  output logic [swr_pkg::ACK_W-1:0]    out_ack_number
);

  swr_pkg::swr_cmd_t    cmd;
  swr_pkg::swr_status_t status;

  // Sequence the work per request
  swr_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Hold window state and produce results
  swr_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_frame_seq   (in_frame_seq),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_valid      (out_valid),
    .out_accepted   (out_accepted),
    .out_ack_valid  (out_ack_valid),
    .out_ack_number (out_ack_number)
  );

endmodule
